[design/assert_macros.svh]
// Assertion macros shared by the duty controller modules.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define MPO_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define MPO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mpo_pkg.sv]
// Shared constants, types and state encodings for the MPPT duty controller.
// No dependencies.
`timescale 1ns / 1ps

package mpo_pkg;

    localparam int DUTY_BITS   = 11;
    localparam int VOLT_W      = 16;
    localparam int CURR_W      = 16;
    localparam int PWR_W       = 32;
    localparam int MARGIN_W    = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // percent scale of the floor margin
    localparam int PCT_SCALE   = 100;
    localparam int PCT_SCALE_W = $clog2(PCT_SCALE + 1);

    // floor dividend margin*(2^DUTY_BITS-1)*vbat and divisor PCT_SCALE*vin
    localparam int NUM_W  = MARGIN_W + VOLT_W + DUTY_BITS;
    localparam int PROD_W = MARGIN_W + VOLT_W;
    localparam int DEN_W  = VOLT_W + PCT_SCALE_W;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    // signed width of a duty step: room for -1 and 2^DUTY_BITS
    localparam int STEP_W = DUTY_BITS + 2;

    localparam logic [DUTY_BITS-1:0] DUTY_CEIL_RST  = DUTY_BITS'(1945);
    localparam logic [MARGIN_W-1:0]  MARGIN_PCT_RST = MARGIN_W'(99);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_CEILING   = 3'd0,
        CFG_FLOOR_MARGIN   = 3'd1,
        CFG_CURRENT_LIMIT  = 3'd2,
        CFG_VOLTAGE_MAX    = 3'd3,
        CFG_MPPT_ENABLE    = 3'd4,
        CFG_CHARGER_MODE   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty_ceiling;
        logic [MARGIN_W-1:0]  floor_margin_pct;
        logic [CURR_W-1:0]    charge_current_limit;
        logic [VOLT_W-1:0]    battery_voltage_max;
        logic                 mppt_enable;
        logic                 charger_mode;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_CLAMP
    } div_state_t;

endpackage

[design/mpo_cfg_regs.sv]
// Configuration register file of the MPPT duty controller.
// Depends on mpo_pkg.
`timescale 1ns / 1ps

module mpo_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mpo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mpo_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mpo_pkg::cfg_t                    cfg
);

    mpo_pkg::cfg_t cfg_reg;
    mpo_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (mpo_pkg::cfg_index_t'(cfg_index))
                mpo_pkg::CFG_DUTY_CEILING:
                    cfg_next.duty_ceiling = cfg_data[mpo_pkg::DUTY_BITS-1:0];
                mpo_pkg::CFG_FLOOR_MARGIN:
                    cfg_next.floor_margin_pct = cfg_data[mpo_pkg::MARGIN_W-1:0];
                mpo_pkg::CFG_CURRENT_LIMIT:
                    cfg_next.charge_current_limit = cfg_data[mpo_pkg::CURR_W-1:0];
                mpo_pkg::CFG_VOLTAGE_MAX:
                    cfg_next.battery_voltage_max = cfg_data[mpo_pkg::VOLT_W-1:0];
                mpo_pkg::CFG_MPPT_ENABLE:
                    cfg_next.mppt_enable = cfg_data[0];
                mpo_pkg::CFG_CHARGER_MODE:
                    cfg_next.charger_mode = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_ceiling         <= mpo_pkg::DUTY_CEIL_RST;
            cfg_reg.floor_margin_pct     <= mpo_pkg::MARGIN_PCT_RST;
            cfg_reg.charge_current_limit <= '0;
            cfg_reg.battery_voltage_max  <= '0;
            cfg_reg.mppt_enable          <= 1'b0;
            cfg_reg.charger_mode         <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/mpo_floor_div.sv]
// Bit-serial restoring divider for the predicted duty floor, with ceiling clamp and a zero floor for zero vin.
// Depends on mpo_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpo_floor_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [mpo_pkg::VOLT_W-1:0]       vin,
    input  logic [mpo_pkg::VOLT_W-1:0]       vbat,
    input  logic [mpo_pkg::MARGIN_W-1:0]     margin,
    input  logic [mpo_pkg::DUTY_BITS-1:0]    ceiling,
    output logic                             done,
    output logic [mpo_pkg::DUTY_BITS-1:0]    floor_duty
);

    mpo_pkg::div_state_t state_reg, state_next;
    logic [mpo_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                          done_reg, done_next;

    // num_reg shifts the dividend out at the top and the quotient in at the bottom
    logic [mpo_pkg::NUM_W-1:0]     num_reg, num_next;
    logic [mpo_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [mpo_pkg::DEN_W-1:0]     den_reg, den_next;
    logic                          vin_zero_reg, vin_zero_next;
    logic [mpo_pkg::DUTY_BITS-1:0] floor_reg, floor_next;

    logic [mpo_pkg::PROD_W-1:0]    prod;
    logic [mpo_pkg::NUM_W-1:0]     num_init;
    logic [mpo_pkg::DEN_W-1:0]     den_init;
    logic [mpo_pkg::DEN_W:0]       rem_shift;
    logic [mpo_pkg::DEN_W:0]       rem_diff;
    logic                          rem_ge;
    logic                          quot_big;
    logic [mpo_pkg::DUTY_BITS-1:0] quot_low;

    assign prod = {{mpo_pkg::VOLT_W{1'b0}}, margin} * {{mpo_pkg::MARGIN_W{1'b0}}, vbat};
    // prod * (2^DUTY_BITS - 1)
    assign num_init = {prod, {mpo_pkg::DUTY_BITS{1'b0}}}
                    - {{mpo_pkg::DUTY_BITS{1'b0}}, prod};
    assign den_init = {{mpo_pkg::PCT_SCALE_W{1'b0}}, vin}
                    * mpo_pkg::DEN_W'(mpo_pkg::PCT_SCALE);

    assign rem_shift = {rem_reg, num_reg[mpo_pkg::NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    assign quot_big = |num_reg[mpo_pkg::NUM_W-1:mpo_pkg::DUTY_BITS];
    assign quot_low = num_reg[mpo_pkg::DUTY_BITS-1:0];

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        done_next     = 1'b0;
        num_next      = num_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        vin_zero_next = vin_zero_reg;
        floor_next    = floor_reg;
        unique case (state_reg)
            mpo_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    num_next      = num_init;
                    den_next      = den_init;
                    rem_next      = '0;
                    vin_zero_next = (vin == '0);
                    cnt_next      = mpo_pkg::CNT_W'(mpo_pkg::NUM_W);
                    state_next    = mpo_pkg::DIV_RUN;
                end
            end
            mpo_pkg::DIV_RUN:
            begin
                if (rem_ge)
                    rem_next = rem_diff[mpo_pkg::DEN_W-1:0];
                else
                    rem_next = rem_shift[mpo_pkg::DEN_W-1:0];
                num_next = {num_reg[mpo_pkg::NUM_W-2:0], rem_ge};
                cnt_next = cnt_reg - mpo_pkg::CNT_W'(1);
                if (cnt_reg == mpo_pkg::CNT_W'(1))
                    state_next = mpo_pkg::DIV_CLAMP;
            end
            mpo_pkg::DIV_CLAMP:
            begin
                if (vin_zero_reg)
                    floor_next = '0;
                else if (quot_big || (quot_low > ceiling))
                    floor_next = ceiling;
                else
                    floor_next = quot_low;
                done_next  = 1'b1;
                state_next = mpo_pkg::DIV_IDLE;
            end
            default:
                state_next = mpo_pkg::DIV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpo_pkg::DIV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        vin_zero_reg <= vin_zero_next;
        floor_reg    <= floor_next;
    end

    assign done       = done_reg;
    assign floor_duty = floor_reg;

    `MPO_ASSERT_IMPL(a_start_idle, start, state_reg == mpo_pkg::DIV_IDLE, "divider restarted while busy")
    `MPO_ASSERT_IMPL(a_done_after_clamp, done_reg, $past(state_reg == mpo_pkg::DIV_CLAMP), "done without clamp")
    `MPO_ASSERT_IMPL(a_rem_bound, state_reg == mpo_pkg::DIV_RUN && den_reg != '0, rem_reg < den_reg, "remainder out of range")

endmodule

[design/mppt_perturb_observe_duty_top.sv]
// Top level of the perturb-and-observe MPPT duty controller with CC-CV limits.
// Depends on mpo_pkg, mpo_cfg_regs, mpo_floor_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
//   Input channel (in_valid / in_stall) takes one sample beat: input voltage,
//   battery voltage, battery current, input power and the fault, pause and
//   recovery flags. Output channel (out_valid / out_stall) returns one beat per
//   sample: the new duty count and the converter enable level.
//   Every sample runs the predicted floor through a one-bit-per-cycle restoring
//   divider of 35 steps and a clamp, so a beat is accepted, its result is
//   registered, and the next sample can be taken once the result is written
//   out when the receiver keeps up. The divider is the limit. The input side
//   stalls while a sample is in work. A finished result waits in the output
//   register while the receiver stalls; a new sample can already be accepted
//   then, but its result is held until the previous beat is taken.
//   Config writes (cfg_write, cfg_index, cfg_data) are registered and are
//   meant for idle periods only; unknown indexes are ignored.
//   Reset clears duty, enable and the stored power and voltage, and loads
//   the register defaults: ceiling 1945, margin 99 percent, charger mode on.

module mppt_perturb_observe_duty_top
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mpo_pkg::VOLT_W-1:0]       input_voltage,
    input  logic [mpo_pkg::VOLT_W-1:0]       battery_voltage,
    input  logic [mpo_pkg::CURR_W-1:0]       battery_current,
    input  logic [mpo_pkg::PWR_W-1:0]        input_power,
    input  logic                             fault_present,
    input  logic                             pause_request,
    input  logic                             recovery_pulse,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mpo_pkg::DUTY_BITS-1:0]    duty,
    output logic                             converter_enable,

    input  logic                             cfg_write,
    input  logic [mpo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mpo_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mpo_pkg::cfg_t       cfg;
    mpo_pkg::ctrl_state_t state_reg, state_next;

    logic                          in_accept;
    logic                          div_done;
    logic [mpo_pkg::DUTY_BITS-1:0] floor_duty;

    // sample latched at accept
    logic [mpo_pkg::VOLT_W-1:0]    vin_lat, vbat_lat;
    logic [mpo_pkg::CURR_W-1:0]    ibat_lat;
    logic [mpo_pkg::PWR_W-1:0]     pin_lat;
    logic                          fault_lat, pause_lat, recover_lat;

    logic [mpo_pkg::DUTY_BITS-1:0] duty_count_reg, duty_count_next;
    logic                          enable_flag_reg, enable_flag_next;
    logic [mpo_pkg::PWR_W-1:0]     prev_power_reg, prev_power_next;
    logic [mpo_pkg::VOLT_W-1:0]    prev_voltage_reg, prev_voltage_next;
    logic                          out_valid_reg, out_valid_next;

    logic                          write_out;
    logic                          step_inc, step_dec, mem_update;
    logic                          cc_hit, cv_hit, cv_below;
    logic                          p_gt, p_lt, v_gt, v_lt;
    logic signed [mpo_pkg::STEP_W-1:0] d_base, d_step, lo_s, hi_s, d_clamp;

    mpo_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpo_floor_div u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_accept),
        .vin        (input_voltage),
        .vbat       (battery_voltage),
        .margin     (cfg.floor_margin_pct),
        .ceiling    (cfg.duty_ceiling),
        .done       (div_done),
        .floor_duty (floor_duty)
    );

    assign in_stall  = (state_reg != mpo_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign write_out = (state_reg == mpo_pkg::ST_OUT) && (!out_valid_reg || !out_stall);

    // step direction
    assign cc_hit   = (ibat_lat > cfg.charge_current_limit);
    assign cv_hit   = (vbat_lat > cfg.battery_voltage_max);
    assign cv_below = (vbat_lat < cfg.battery_voltage_max);
    assign p_gt     = (pin_lat > prev_power_reg);
    assign p_lt     = (pin_lat < prev_power_reg);
    assign v_gt     = (vin_lat > prev_voltage_reg);
    assign v_lt     = (vin_lat < prev_voltage_reg);

    always_comb
    begin
        step_inc   = 1'b0;
        step_dec   = 1'b0;
        mem_update = 1'b0;
        if (cc_hit || cv_hit)
            step_dec = 1'b1;
        else if (!cfg.mppt_enable)
            step_inc = cv_below;
        else
        begin
            mem_update = 1'b1;
            if ((p_gt && v_gt) || (p_lt && v_lt))
                step_dec = 1'b1;
            else if ((p_gt && v_lt) || (p_lt && v_gt))
                step_inc = 1'b1;
            else
                step_inc = cv_below;
        end
    end

    assign d_base = signed'({2'b00, duty_count_reg});
    assign lo_s   = cfg.charger_mode ? signed'({2'b00, floor_duty}) : '0;
    assign hi_s   = signed'({2'b00, cfg.duty_ceiling});

    always_comb
    begin
        if (step_inc)
            d_step = d_base + mpo_pkg::STEP_W'(1);
        else if (step_dec)
            d_step = d_base - mpo_pkg::STEP_W'(1);
        else
            d_step = d_base;
        d_clamp = d_step;
        if (d_clamp < lo_s)
            d_clamp = lo_s;
        if (d_clamp > hi_s)
            d_clamp = hi_s;
    end

    always_comb
    begin
        state_next        = state_reg;
        duty_count_next   = duty_count_reg;
        enable_flag_next  = enable_flag_reg;
        prev_power_next   = prev_power_reg;
        prev_voltage_next = prev_voltage_reg;
        out_valid_next    = out_valid_reg && out_stall;
        unique case (state_reg)
            mpo_pkg::ST_IDLE:
            begin
                if (in_accept)
                    state_next = mpo_pkg::ST_DIV;
            end
            mpo_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = mpo_pkg::ST_OUT;
            end
            mpo_pkg::ST_OUT:
            begin
                if (write_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = mpo_pkg::ST_IDLE;
                    if (fault_lat || pause_lat)
                    begin
                        duty_count_next  = '0;
                        enable_flag_next = 1'b0;
                    end
                    else if (recover_lat)
                        duty_count_next = floor_duty;
                    else
                    begin
                        duty_count_next  = d_clamp[mpo_pkg::DUTY_BITS-1:0];
                        enable_flag_next = 1'b1;
                        if (mem_update)
                        begin
                            prev_power_next   = pin_lat;
                            prev_voltage_next = vin_lat;
                        end
                    end
                end
            end
            default:
                state_next = mpo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mpo_pkg::ST_IDLE;
            duty_count_reg   <= '0;
            enable_flag_reg  <= 1'b0;
            prev_power_reg   <= '0;
            prev_voltage_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            duty_count_reg   <= duty_count_next;
            enable_flag_reg  <= enable_flag_next;
            prev_power_reg   <= prev_power_next;
            prev_voltage_reg <= prev_voltage_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            vin_lat     <= input_voltage;
            vbat_lat    <= battery_voltage;
            ibat_lat    <= battery_current;
            pin_lat     <= input_power;
            fault_lat   <= fault_present;
            pause_lat   <= pause_request;
            recover_lat <= recovery_pulse;
        end
    end

    // duty state only moves when the output register is free, so it is the payload
    assign out_valid        = out_valid_reg;
    assign duty             = duty_count_reg;
    assign converter_enable = enable_flag_reg;

    `MPO_ASSERT_NEXT(a_fault_clears, write_out && (fault_lat || pause_lat), duty == '0 && !converter_enable, "fault beat did not clear duty")
    `MPO_ASSERT_NEXT(a_duty_ceiling, write_out, duty_count_reg <= $past(cfg.duty_ceiling), "duty above ceiling")
    `MPO_ASSERT_IMPL(a_out_from_step, $rose(out_valid_reg), $past(state_reg == mpo_pkg::ST_OUT), "result beat without a step")

endmodule
